// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define EPWC_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a signal is unchanged in the cycle after a condition.
`define EPWC_ASSERT_HOLD(name, clk, rst_n, cond, sig, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
    else $error(msg);

`endif

// ===== hw/rtl/epwc_pkg.sv =====
// Shared types and constants for the edge pulse width capture block.
// Depends on nothing.
package epwc_pkg;

  localparam int unsigned TimeW     = 64;
  localparam int unsigned DurW      = 32;
  localparam int unsigned PinW      = 5;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned BurstMin  = 4;
  localparam logic [DurW-1:0] SilenceReset = 32'd10000;

  typedef enum logic [1:0] {
    MODE_EDGE  = 2'd0,
    MODE_START = 2'd1,
    MODE_STOP  = 2'd2,
    MODE_READ  = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SILENCE_US = 2'd0,
    CFG_DATA_PIN   = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic            level;
    logic [DurW-1:0] dur;
  } pulse_rec_t;

endpackage

// ===== hw/rtl/epwc_if.sv =====
// Channel interfaces of the edge pulse width capture block.
// Depends on epwc_pkg for field widths.
interface epwc_in_if #(parameter int unsigned IdxW = 9);
  import epwc_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          mode;
  logic [TimeW-1:0]    time_us;
  logic [PinW-1:0]     edge_pin;
  logic                edge_rising;
  logic [IdxW-1:0]     read_index;

  modport source (output valid, mode, time_us, edge_pin, edge_rising, read_index,
                  input ready);
  modport sink   (input valid, mode, time_us, edge_pin, edge_rising, read_index,
                  output ready);
endinterface

interface epwc_out_if #(parameter int unsigned CntW = 10);
  import epwc_pkg::*;
  logic                valid;
  logic                ready;
  logic                running;
  logic [CntW-1:0]     sample_count;
  logic                burst_ready;
  logic                read_valid;
  logic [DurW-1:0]     read_duration_us;
  logic                read_level;
  logic [TimeW-1:0]    burst_start_us;
  logic [TimeW-1:0]    last_edge_us;

  modport source (output valid, running, sample_count, burst_ready, read_valid,
                  read_duration_us, read_level, burst_start_us, last_edge_us,
                  input ready);
  modport sink   (input valid, running, sample_count, burst_ready, read_valid,
                  read_duration_us, read_level, burst_start_us, last_edge_us,
                  output ready);
endinterface

interface epwc_cfg_if;
  import epwc_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/epwc_store.sv =====
// Pulse record store: single write port, one registered read port.
// Depends on epwc_pkg for the record type.
module epwc_store #(
  parameter int unsigned Depth = 512,
  parameter int unsigned AddrW = 9
) (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [AddrW-1:0]    wr_addr_i,
  input  epwc_pkg::pulse_rec_t wr_data_i,
  input  logic                rd_en_i,
  input  logic [AddrW-1:0]    rd_addr_i,
  output epwc_pkg::pulse_rec_t rd_data_o
);
  import epwc_pkg::*;

  pulse_rec_t mem [Depth];
  pulse_rec_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hw/rtl/edge_pulse_width_capture_top.sv =====
// Top level of the edge pulse width capture block: burst state, pulse store, output stage.
// Depends on epwc_pkg, epwc_if and epwc_store.
//
//   channel  dir  word
//   in_i     in   mode, time_us, edge_pin, edge_rising, read_index
//   out_o    out  running, sample_count, burst_ready, read_*, burst_start_us, last_edge_us
//   cfg_i    in   index, data (0 silence_us, 1 data_pin)
//
// One word per cycle sustained while out_o takes words; the store read and stage one
// load on the edge that takes a word; the output register loads from stage one when free.
// Reset clears control state only; the store holds garbage until written, and no
// clearing pass runs.
// A stalled output holds its word; the input keeps taking words until both stages fill.
module edge_pulse_width_capture_top #(
  parameter int unsigned MAX_PULSES = 512
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  epwc_in_if.sink          in_i,
  epwc_out_if.source       out_o,
  epwc_cfg_if.sink         cfg_i
);
  import epwc_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_PULSES);
  localparam int unsigned CntW = $clog2(MAX_PULSES + 1);
  localparam logic [CntW-1:0] MaxCount = CntW'(MAX_PULSES);
  localparam logic [CntW-1:0] MinCount = CntW'(BurstMin);

  logic [DurW-1:0]  silence_q;
  logic [PinW-1:0]  pin_q;

  logic [CntW-1:0]  count_q, count_d;
  logic             armed_q, armed_d;
  logic             seen_q, seen_d;
  logic [TimeW-1:0] burst_q, burst_d;
  logic [TimeW-1:0] last_q, last_d;

  logic             in_fire;
  logic             s1_valid_q, s1_valid_d;
  logic             s2_take, s1_adv;

  logic             s1_running_q;
  logic [CntW-1:0]  s1_count_q;
  logic             s1_ready_q;
  logic             s1_rd_valid_q;
  logic [TimeW-1:0] s1_burst_q;
  logic [TimeW-1:0] s1_last_q;

  logic             out_valid_q, out_valid_d;
  logic             out_running_q;
  logic [CntW-1:0]  out_count_q;
  logic             out_ready_flag_q;
  logic             out_rd_valid_q;
  logic [DurW-1:0]  out_dur_q;
  logic             out_level_q;
  logic [TimeW-1:0] out_burst_q;
  logic [TimeW-1:0] out_last_q;

  logic [TimeW-1:0] span, quiet;
  logic             wr_en, rd_en, rd_valid, burst_ready;
  pulse_rec_t       wr_rec, rd_rec;
  mode_e            mode;

  // Configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      silence_q <= SilenceReset;
      pin_q     <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        CFG_SILENCE_US: silence_q <= cfg_i.data[DurW-1:0];
        CFG_DATA_PIN:   pin_q     <= cfg_i.data[PinW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake
  assign s2_take     = !out_valid_q || out_o.ready;
  assign s1_adv      = s1_valid_q && s2_take;
  assign in_i.ready  = !s1_valid_q || s2_take;
  assign in_fire     = in_i.valid && in_i.ready;
  assign s1_valid_d  = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
  assign out_valid_d = s1_adv ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  // Burst state update
  assign mode = mode_e'(in_i.mode);
  assign span = in_i.time_us - last_q;
  assign wr_rec.level = ~in_i.edge_rising;
  assign wr_rec.dur   = (|span[TimeW-1:DurW]) ? '1 : span[DurW-1:0];

  always_comb begin
    count_d  = count_q;
    armed_d  = armed_q;
    seen_d   = seen_q;
    burst_d  = burst_q;
    last_d   = last_q;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    rd_valid = 1'b0;
    unique case (mode)
      MODE_EDGE: begin
        if (armed_q && in_i.edge_pin == pin_q) begin
          last_d = in_i.time_us;
          if (!seen_q) begin
            seen_d  = 1'b1;
            burst_d = in_i.time_us;
          end else if (count_q >= MaxCount) begin
            armed_d = 1'b0;
          end else begin
            wr_en   = in_fire;
            count_d = count_q + 1'b1;
          end
        end
      end
      MODE_START: begin
        count_d = '0;
        armed_d = 1'b1;
        seen_d  = 1'b0;
        burst_d = '0;
        last_d  = '0;
      end
      MODE_STOP: begin
        armed_d = 1'b0;
      end
      MODE_READ: begin
        rd_en    = in_fire;
        rd_valid = (CntW'(in_i.read_index) < count_q) &&
                   (CntW'(in_i.read_index) < MaxCount);
      end
      default: ;
    endcase
  end

  assign quiet       = in_i.time_us - last_d;
  assign burst_ready = (count_d >= MinCount) && seen_d &&
                       (quiet >= TimeW'(silence_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      armed_q <= 1'b0;
      seen_q  <= 1'b0;
      burst_q <= '0;
      last_q  <= '0;
    end else if (in_fire) begin
      count_q <= count_d;
      armed_q <= armed_d;
      seen_q  <= seen_d;
      burst_q <= burst_d;
      last_q  <= last_d;
    end
  end

  // Store; a read never targets the entry being written: no word both reads and writes
  epwc_store #(
    .Depth (MAX_PULSES),
    .AddrW (IdxW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q[IdxW-1:0]),
    .wr_data_i (wr_rec),
    .rd_en_i   (rd_en),
    .rd_addr_i (in_i.read_index[IdxW-1:0]),
    .rd_data_o (rd_rec)
  );

  // Stage one: wait for store read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_running_q  <= armed_d;
      s1_count_q    <= count_d;
      s1_ready_q    <= burst_ready;
      s1_rd_valid_q <= rd_valid;
      s1_burst_q    <= burst_d;
      s1_last_q     <= last_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_running_q    <= s1_running_q;
      out_count_q      <= s1_count_q;
      out_ready_flag_q <= s1_ready_q;
      out_rd_valid_q   <= s1_rd_valid_q;
      out_dur_q        <= s1_rd_valid_q ? rd_rec.dur : '0;
      out_level_q      <= s1_rd_valid_q & rd_rec.level;
      out_burst_q      <= s1_burst_q;
      out_last_q       <= s1_last_q;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.running          = out_running_q;
  assign out_o.sample_count     = out_count_q;
  assign out_o.burst_ready      = out_ready_flag_q;
  assign out_o.read_valid       = out_rd_valid_q;
  assign out_o.read_duration_us = out_dur_q;
  assign out_o.read_level       = out_level_q;
  assign out_o.burst_start_us   = out_burst_q;
  assign out_o.last_edge_us     = out_last_q;

endmodule

// ===== hw/rtl/epwc_checker.sv =====
// Port-level checks for the edge pulse width capture top level, attached by bind.
// Depends on assert_macros.svh and epwc_pkg.
`include "assert_macros.svh"

module epwc_checker #(
  parameter int unsigned CntW = 10
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [CntW-1:0]            sample_count_i,
  input logic                       burst_ready_i,
  input logic                       read_valid_i,
  input logic [epwc_pkg::DurW-1:0]  read_duration_us_i,
  input logic                       read_level_i
);
  import epwc_pkg::*;

  `EPWC_ASSERT(a_out_hold, clk_i, rst_ni,
               out_valid_i && !out_ready_i |=> out_valid_i,
               "output word dropped while stalled")
  `EPWC_ASSERT_HOLD(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i,
                    sample_count_i, "count changed while stalled")
  `EPWC_ASSERT(a_rd_zero, clk_i, rst_ni,
               out_valid_i && !read_valid_i |->
               read_duration_us_i == '0 && read_level_i == 1'b0,
               "read fields not zero without a valid read")
  `EPWC_ASSERT(a_rd_count, clk_i, rst_ni,
               out_valid_i && read_valid_i |-> sample_count_i != '0,
               "valid read with empty store")
  `EPWC_ASSERT(a_burst_min, clk_i, rst_ni,
               out_valid_i && burst_ready_i |-> sample_count_i >= CntW'(BurstMin),
               "burst ready below minimum count")

endmodule

bind edge_pulse_width_capture_top epwc_checker #(
  .CntW (CntW)
) u_epwc_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .sample_count_i     (out_o.sample_count),
  .burst_ready_i      (out_o.burst_ready),
  .read_valid_i       (out_o.read_valid),
  .read_duration_us_i (out_o.read_duration_us),
  .read_level_i       (out_o.read_level)
);

// ===== test/tb_edge_pulse_width_capture_top.sv =====
`timescale 1ns / 1ps
// Testbench for edge_pulse_width_capture_top: a directed table, random bursts and noise, and a
// store fill; each word is checked against table values or a predictor of the capture state.
// Depends on epwc_pkg, epwc_if and the RTL of the block.
module tb_edge_pulse_width_capture_top;
  import epwc_pkg::*;

  localparam int unsigned MaxRecords = 512;
  localparam int unsigned IdxW       = 9;
  localparam int unsigned CntW       = 10;
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 2'd3;

  typedef struct {
    mode_e              mode;
    logic [TimeW-1:0]   t;
    logic [PinW-1:0]    pin;
    logic               rising;
    logic [IdxW-1:0]    idx;
  } cap_word_t;

  typedef struct {
    logic               running;
    logic [CntW-1:0]    count;
    logic               ready;
    logic               rvalid;
    logic [DurW-1:0]    dur;
    logic               lvl;
    logic [TimeW-1:0]   bstart;
    logic [TimeW-1:0]   last;
  } capture_res_t;

  typedef struct {
    cap_word_t          w;
    bit                 typed;
    capture_res_t       want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  epwc_in_if #(.IdxW(IdxW)) in_if ();
  epwc_out_if #(.CntW(CntW)) out_if ();
  epwc_cfg_if cfg_if ();

  edge_pulse_width_capture_top #(
    .MAX_PULSES(MaxRecords)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  logic [DurW-1:0]  rec_dur [MaxRecords];
  logic             rec_lvl [MaxRecords];
  int unsigned      rec_count;
  logic             cap_armed;
  logic             first_seen;
  logic [TimeW-1:0] prev_edge_t;
  logic [TimeW-1:0] burst_t0;
  logic [TimeW-1:0] last_edge_t;
  logic [DurW-1:0]  cfg_silence;
  logic [PinW-1:0]  cfg_pin;

  capture_res_t     pending_results [$];
  stim_row_t        stim_table [$];
  capture_res_t     no_res;
  logic [TimeW-1:0] now_t;
  int unsigned      src_idle_pct;
  int unsigned      snk_idle_pct;
  int               hold_left;
  int               n_fail;

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic capture_res_t predict_capture(cap_word_t w);
    capture_res_t r;
    logic [TimeW-1:0] span;
    r = '{default: '0};
    case (w.mode)
      MODE_EDGE: begin
        if (cap_armed && w.pin == cfg_pin) begin
          if (!first_seen) begin
            first_seen  = 1'b1;
            prev_edge_t = w.t;
            burst_t0    = w.t;
            last_edge_t = w.t;
          end else begin
            span        = w.t - prev_edge_t;
            prev_edge_t = w.t;
            last_edge_t = w.t;
            if (rec_count >= MaxRecords) begin
              cap_armed = 1'b0;
            end else begin
              rec_dur[IdxW'(rec_count)] = (span > 64'hFFFF_FFFF) ? '1 : span[DurW-1:0];
              rec_lvl[IdxW'(rec_count)] = ~w.rising;
              rec_count++;
            end
          end
        end
      end
      MODE_START: begin
        rec_count   = 0;
        first_seen  = 1'b0;
        prev_edge_t = '0;
        burst_t0    = '0;
        last_edge_t = '0;
        cap_armed   = 1'b1;
      end
      MODE_STOP: begin
        cap_armed = 1'b0;
      end
      default: begin
        if (w.idx < rec_count) begin
          r.rvalid = 1'b1;
          r.dur    = rec_dur[w.idx];
          r.lvl    = rec_lvl[w.idx];
        end
      end
    endcase
    r.ready   = rec_count >= BurstMin && first_seen &&
                (w.t - last_edge_t) >= TimeW'(cfg_silence);
    r.running = cap_armed;
    r.count   = CntW'(rec_count);
    r.bstart  = burst_t0;
    r.last    = last_edge_t;
    return r;
  endfunction

  function automatic cap_word_t mk_word(mode_e m, logic [TimeW-1:0] t, logic [PinW-1:0] p,
                                        logic rise, logic [IdxW-1:0] i);
    cap_word_t w;
    w.mode   = m;
    w.t      = t;
    w.pin    = p;
    w.rising = rise;
    w.idx    = i;
    return w;
  endfunction

  function automatic capture_res_t status(logic run, logic [CntW-1:0] cnt,
                                          logic [TimeW-1:0] t0, logic [TimeW-1:0] tl);
    capture_res_t r;
    r         = '{default: '0};
    r.running = run;
    r.count   = cnt;
    r.bstart  = t0;
    r.last    = tl;
    return r;
  endfunction

  function automatic stim_row_t row(mode_e m, logic [TimeW-1:0] t, logic [PinW-1:0] p,
                                    logic rise, logic [IdxW-1:0] i, bit typed,
                                    capture_res_t want);
    stim_row_t s;
    s.w     = mk_word(m, t, p, rise, i);
    s.typed = typed;
    s.want  = want;
    return s;
  endfunction

  function automatic logic [IdxW-1:0] near_index();
    if ($urandom_range(0, 4) == 0) return IdxW'($urandom);
    return IdxW'($urandom_range(0, rec_count + 1));
  endfunction

  task automatic check_field(string name, logic [TimeW-1:0] want, logic [TimeW-1:0] got);
    if (got !== want) begin
      n_fail++;
      if (n_fail <= 10) begin
        $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, name, want, got);
      end
    end
  endtask

  task automatic send_word(input cap_word_t w, input bit typed, input capture_res_t want);
    capture_res_t got;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.mode        <= w.mode;
    in_if.time_us     <= w.t;
    in_if.edge_pin    <= w.pin;
    in_if.edge_rising <= w.rising;
    in_if.read_index  <= w.idx;
    do @(posedge clk_i); while (!in_if.ready);
    got = predict_capture(w);
    pending_results.push_back(typed ? want : got);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == CFG_SILENCE_US) begin
      cfg_silence = data;
    end else if (idx == CFG_DATA_PIN) begin
      cfg_pin = data[PinW-1:0];
    end
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic random_phase(input int n_words);
    int sent;
    int n_edges;
    int r;
    logic [TimeW-1:0] tt;
    logic [PinW-1:0] p;
    logic rise;
    sent = 0;
    rise = 1'b1;
    while (sent < n_words) begin
      if ($urandom_range(0, 9) < 7) begin
        send_word(mk_word(MODE_START, now_t, PinW'($urandom), 1'($urandom), IdxW'($urandom)),
                  1'b0, no_res);
        sent++;
        n_edges = ($urandom_range(0, 2) == 0) ? $urandom_range(3, 6) : $urandom_range(1, 16);
        repeat (n_edges) begin
          r = $urandom_range(0, 19);
          case (r)
            0: now_t = now_t + {$urandom, $urandom};
            1: now_t = now_t - $urandom_range(1, 1000);
            2: now_t = now_t;
            3: now_t = now_t + 64'hFFFF_FFFF;
            default: now_t = now_t + $urandom_range(1, 3000);
          endcase
          rise = ($urandom_range(0, 9) == 0) ? rise : ~rise;
          p    = ($urandom_range(0, 9) == 0) ? PinW'($urandom) : cfg_pin;
          send_word(mk_word(MODE_EDGE, now_t, p, rise, IdxW'($urandom)), 1'b0, no_res);
          sent++;
          if ($urandom_range(0, 3) == 0) begin
            send_word(mk_word(MODE_READ, now_t, PinW'($urandom), 1'($urandom), near_index()),
                      1'b0, no_res);
            sent++;
          end
        end
        repeat ($urandom_range(1, 4)) begin
          tt = last_edge_t + TimeW'(cfg_silence);
          r  = $urandom_range(0, 3);
          if (r == 0) begin
            tt = tt - 1;
          end else if (r == 2) begin
            tt = tt + 1;
          end else if (r == 3) begin
            tt = {$urandom, $urandom};
          end
          send_word(mk_word(MODE_READ, tt, PinW'($urandom), 1'($urandom), near_index()),
                    1'b0, no_res);
          sent++;
        end
        if ($urandom_range(0, 2) == 0) begin
          send_word(mk_word(MODE_STOP, now_t, PinW'($urandom), 1'($urandom), IdxW'($urandom)),
                    1'b0, no_res);
          sent++;
        end
      end else begin
        repeat ($urandom_range(1, 5)) begin
          send_word(mk_word(mode_e'($urandom_range(0, 3)), {$urandom, $urandom},
                            PinW'($urandom), 1'($urandom), IdxW'($urandom)), 1'b0, no_res);
          sent++;
        end
      end
    end
  endtask

  task automatic fill_store();
    logic rise;
    rise = 1'b0;
    @(posedge clk_i);
    hold_left = 400;
    send_word(mk_word(MODE_START, now_t, '0, 1'b0, '0), 1'b0, no_res);
    repeat (MaxRecords + 8) begin
      now_t = now_t + $urandom_range(1, 500);
      rise  = ~rise;
      send_word(mk_word(MODE_EDGE, now_t, cfg_pin, rise, '0), 1'b0, no_res);
    end
    send_word(mk_word(MODE_READ, now_t, '0, 1'b0, '0), 1'b0, no_res);
    send_word(mk_word(MODE_READ, now_t, '0, 1'b0, '1), 1'b0, no_res);
    send_word(mk_word(MODE_READ, now_t + TimeW'(cfg_silence), '0, 1'b0, IdxW'(MaxRecords / 2)),
              1'b0, no_res);
  endtask

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    capture_res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        n_fail++;
        if (n_fail <= 10) begin
          $display("%0t: result word with nothing expected", $realtime);
        end
      end else begin
        want = pending_results.pop_front();
        check_field("running", TimeW'(want.running), TimeW'(out_if.running));
        check_field("sample_count", TimeW'(want.count), TimeW'(out_if.sample_count));
        check_field("burst_ready", TimeW'(want.ready), TimeW'(out_if.burst_ready));
        check_field("read_valid", TimeW'(want.rvalid), TimeW'(out_if.read_valid));
        check_field("read_duration_us", TimeW'(want.dur), TimeW'(out_if.read_duration_us));
        check_field("read_level", TimeW'(want.lvl), TimeW'(out_if.read_level));
        check_field("burst_start_us", want.bstart, out_if.burst_start_us);
        check_field("last_edge_us", want.last, out_if.last_edge_us);
      end
    end
  end

  initial begin
    in_if.valid       = 1'b0;
    in_if.mode        = MODE_EDGE;
    in_if.time_us     = '0;
    in_if.edge_pin    = '0;
    in_if.edge_rising = 1'b0;
    in_if.read_index  = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = CFG_SILENCE_US;
    cfg_if.data       = '0;
    out_if.ready      = 1'b0;
    rst_ni            = 1'b0;
    hold_left         = 0;
    n_fail            = 0;
    src_idle_pct      = 0;
    snk_idle_pct      = 0;
    now_t             = 64'd1000;
    no_res            = '{default: '0};
    rec_count         = 0;
    cap_armed         = 1'b0;
    first_seen        = 1'b0;
    prev_edge_t       = '0;
    burst_t0          = '0;
    last_edge_t       = '0;
    cfg_silence       = SilenceReset;
    cfg_pin           = '0;

    stim_table.push_back(row(MODE_READ,  64'd0,    5'd0, 1'b0, 9'd0,   1'b1,
                             status(1'b0, '0, '0, '0)));
    stim_table.push_back(row(MODE_EDGE,  64'd100,  5'd0, 1'b1, 9'd0,   1'b1,
                             status(1'b0, '0, '0, '0)));
    stim_table.push_back(row(MODE_STOP,  64'd0,    5'd0, 1'b0, 9'd0,   1'b1,
                             status(1'b0, '0, '0, '0)));
    stim_table.push_back(row(MODE_START, 64'd0,    5'd0, 1'b0, 9'd0,   1'b1,
                             status(1'b1, '0, '0, '0)));
    stim_table.push_back(row(MODE_EDGE,  64'd50,   5'd5, 1'b1, 9'd0,   1'b1,
                             status(1'b1, '0, '0, '0)));
    stim_table.push_back(row(MODE_EDGE,  64'd1000, 5'd0, 1'b1, 9'd0,   1'b1,
                             status(1'b1, '0, 64'd1000, 64'd1000)));
    stim_table.push_back(row(MODE_EDGE,  64'd1000, 5'd0, 1'b0, 9'd0,   1'b0, no_res));
    stim_table.push_back(row(MODE_EDGE,  64'h1_0000_03E7, 5'd0, 1'b1, 9'd0, 1'b0, no_res));
    stim_table.push_back(row(MODE_EDGE,  64'h2_0000_03E7, 5'd0, 1'b0, 9'd0, 1'b0, no_res));
    stim_table.push_back(row(MODE_EDGE,  64'd5,    5'd0, 1'b1, 9'd0,   1'b0, no_res));
    stim_table.push_back(row(MODE_EDGE,  64'd6,    5'd0, 1'b0, 9'd0,   1'b0, no_res));
    stim_table.push_back(row(MODE_READ,  64'd6,    5'd0, 1'b0, 9'd0,   1'b0, no_res));
    stim_table.push_back(row(MODE_READ,  64'd6,    5'd0, 1'b0, 9'd1,   1'b0, no_res));
    stim_table.push_back(row(MODE_READ,  64'd6,    5'd0, 1'b0, 9'd2,   1'b0, no_res));
    stim_table.push_back(row(MODE_READ,  64'd6,    5'd0, 1'b0, 9'd4,   1'b0, no_res));
    stim_table.push_back(row(MODE_READ,  64'd6,    5'd0, 1'b0, 9'd5,   1'b0, no_res));
    stim_table.push_back(row(MODE_READ,  64'd6,    5'd0, 1'b0, 9'd511, 1'b0, no_res));
    stim_table.push_back(row(MODE_READ,  64'd10005, 5'd0, 1'b0, 9'd3,  1'b0, no_res));
    stim_table.push_back(row(MODE_READ,  64'd10006, 5'd0, 1'b0, 9'd3,  1'b0, no_res));
    stim_table.push_back(row(MODE_READ,  '1,       5'd31, 1'b1, 9'd3,  1'b0, no_res));
    stim_table.push_back(row(MODE_START, 64'd7,    5'd0, 1'b0, 9'd0,   1'b1,
                             status(1'b1, '0, '0, '0)));
    stim_table.push_back(row(MODE_READ,  64'd7,    5'd0, 1'b0, 9'd0,   1'b1,
                             status(1'b1, '0, '0, '0)));
    stim_table.push_back(row(MODE_STOP,  64'd8,    5'd0, 1'b0, 9'd0,   1'b1,
                             status(1'b0, '0, '0, '0)));
    stim_table.push_back(row(MODE_EDGE,  64'd9,    5'd0, 1'b1, 9'd0,   1'b1,
                             status(1'b0, '0, '0, '0)));

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (stim_table[i]) begin
      send_word(stim_table[i].w, stim_table[i].typed, stim_table[i].want);
    end
    drain();

    cfg_write(CFG_SILENCE_US, 32'd0);
    cfg_write(CFG_DATA_PIN, CfgDataW'(31));
    cfg_write(CfgSpareLo, $urandom);
    src_idle_pct = 25;
    snk_idle_pct = 63;
    random_phase(70);
    drain();

    cfg_write(CFG_SILENCE_US, 32'hFFFF_FFFF);
    cfg_write(CFG_DATA_PIN, CfgDataW'(0));
    cfg_write(CfgSpareHi, $urandom);
    src_idle_pct = 63;
    snk_idle_pct = 25;
    random_phase(70);
    drain();

    cfg_write(CFG_SILENCE_US, $urandom_range(0, 5000));
    cfg_write(CFG_DATA_PIN, CfgDataW'($urandom_range(0, 31)));
    src_idle_pct = 0;
    snk_idle_pct = 0;
    fill_store();
    random_phase(60);
    drain();

    repeat (10) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      n_fail++;
      $display("%0d expected result words never arrived", pending_results.size());
    end
    if (n_fail == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
